// ===== rtl/signed_division_magic_number_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the signed division planner.
// ---------------------------------------------------------------------------
`ifndef SIGNED_DIVISION_MAGIC_NUMBER_MACROS_SVH
`define SIGNED_DIVISION_MAGIC_NUMBER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smn_pkg.sv =====
// ---------------------------------------------------------------------------
// Signed division planner package
// Widths, result codes, sequencer states and control structures.
// ---------------------------------------------------------------------------
package smn_pkg;

    localparam int DATA_W    = 32;
    localparam int DIVISOR_W = 32;
    localparam int MULT_W    = 32;
    localparam int SHIFT_W   = 5;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = $clog2(DATA_W);
    localparam int STEPS_W   = $clog2(2 * DATA_W + 1);
    localparam int LG_W      = $clog2(DATA_W);

    localparam logic [DATA_W-1:0]  TOP_BIT   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(DATA_W - 1);
    localparam logic [STEPS_W-1:0] STEPS_MAX = STEPS_W'(2 * DATA_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_MAGIC = 2'd0,
        KIND_POW2  = 2'd1,
        KIND_UNIT  = 2'd2,
        KIND_ZERO  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIV_T,
        ST_ANC,
        ST_DIV_A,
        ST_DIV_M,
        ST_SRCH1,
        ST_SRCH2,
        ST_TEST,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIV_T,
        OP_DIV_A,
        OP_DIV_M,
        OP_SRCH_1,
        OP_SRCH_2
    } t_op;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic classify;
        logic anc_load;
        logic finish;
        logic last;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic trivial;
        logic search_more;
    } t_status;

endpackage

// ===== rtl/signed_division_magic_number.sv =====
// ---------------------------------------------------------------------------
// Signed division magic number planner
// Turns a signed constant divisor into a multiply-and-shift division plan.
// ---------------------------------------------------------------------------
// One request carries a signed divisor and yields one result. Zero is
// reported as invalid, plus or minus one as a trivial divisor, and a
// power-of-two magnitude with its log2 as the shift. Any other divisor gets
// the signed magic multiplier M and post-shift s: the quotient is the high
// half of n*M, plus n or minus n when needs_fix is set (the signs of M and the
// divisor differ), shifted right arithmetically by s, plus one when the
// intermediate result is negative. The block takes one request at a time and
// holds o_in_ready low until its result has been taken. A trivial divisor
// goes from classification straight to the result. A general divisor runs
// through a single shared shift-subtract unit that performs three bit-serial
// divisions of one bit per cycle and then both remainder updates of each
// search iteration in turn; the search runs at most 2*DATA_W iterations,
// typically under DATA_W.
// ---------------------------------------------------------------------------
module signed_division_magic_number
    import smn_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [DIVISOR_W-1:0] i_divisor,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [KIND_W-1:0]           o_kind,
    output logic signed [MULT_W-1:0]    o_magic_multiplier,
    output logic [SHIFT_W-1:0]          o_shift_amount,
    output logic                        o_needs_fix,
    output logic                        o_divisor_negative
);

`include "signed_division_magic_number_macros.svh"

    t_ctrl   ctrl;
    t_status status;

    // Input and classification registers.
    logic [DATA_W-1:0]  r_d, n_d;
    logic               r_neg, n_neg;
    logic [DATA_W-1:0]  r_mag, n_mag;

    // Division working registers: dividend shifter, remainder and quotient.
    logic [DATA_W-1:0]  r_dvd, n_dvd;
    logic [DATA_W-1:0]  r_rem, n_rem;
    logic [DATA_W-1:0]  r_quo, n_quo;

    // Search registers.
    logic [DATA_W-1:0]  r_anc, n_anc;
    logic [DATA_W-1:0]  r_q1, n_q1;
    logic [DATA_W-1:0]  r_r1, n_r1;
    logic [DATA_W-1:0]  r_q2, n_q2;
    logic [DATA_W-1:0]  r_r2, n_r2;
    logic [STEPS_W-1:0] r_steps, n_steps;

    // Result registers.
    t_kind              r_kind, n_kind;
    logic [DATA_W-1:0]  r_mult, n_mult;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic               r_fix, n_fix;
    logic               r_dneg, n_dneg;

    // Shared unit operands and results.
    logic [DATA_W-1:0]  u_rem_in, u_quo_in, u_den;
    logic               u_bit;
    logic [DATA_W-1:0]  u_rem, u_quo;

    // Classification of the held divisor.
    logic               d_neg;
    logic [DATA_W-1:0]  d_mag;
    logic               d_zero, d_one, d_pow2;
    logic [LG_W-1:0]    d_log2;

    // Anc, search exit test and final multiplier.
    logic [DATA_W-1:0]  t_val;
    logic [DATA_W-1:0]  anc_raw;
    logic [DATA_W-1:0]  delta;
    logic [DATA_W-1:0]  mult_fin;
    logic               mult_neg;

    smn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    smn_step_unit u_step (
        .i_rem (u_rem_in),
        .i_quo (u_quo_in),
        .i_den (u_den),
        .i_bit (u_bit),
        .o_rem (u_rem),
        .o_quo (u_quo)
    );

    // The held divisor is split into sign and magnitude; the most negative
    // value keeps its bit pattern and so lands on the top power of two.
    always_comb begin
        d_neg  = r_d[DATA_W-1];
        d_mag  = d_neg ? (DATA_W'(0) - r_d) : r_d;
        d_zero = (r_d == '0);
        d_one  = (d_mag == DATA_W'(1));
        d_pow2 = ((d_mag & (d_mag - DATA_W'(1))) == '0);
        d_log2 = '0;
        for (int i = 0; i < DATA_W; i++) begin
            d_log2 = d_log2 | (d_mag[i] ? LG_W'(i) : LG_W'(0));
        end
    end

    // The first division works on t = 2^(W-1) plus one for a negative divisor.
    assign t_val   = TOP_BIT | DATA_W'(r_neg);
    assign anc_raw = t_val - DATA_W'(1) - r_rem;
    assign delta   = r_mag - r_r2;

    // Negating q2 + 1 is the same as inverting q2.
    assign mult_fin = r_neg ? ~r_q2 : (r_q2 + DATA_W'(1));
    assign mult_neg = mult_fin[DATA_W-1];

    // The search keeps going while q1 is below delta, or equal to it with a
    // zero remainder, and the step guard has not run out.
    always_comb begin
        status.in_valid    = i_in_valid;
        status.out_ready   = i_out_ready;
        status.trivial     = d_zero || d_one || d_pow2;
        status.search_more = ((r_q1 < delta) || ((r_q1 == delta) && (r_r1 == '0)))
                             && (r_steps < STEPS_MAX);
    end

    // Operand routing for the shared unit.
    always_comb begin
        u_rem_in = '0;
        u_quo_in = '0;
        u_den    = '0;
        u_bit    = 1'b0;
        case (ctrl.op)
            OP_DIV_T: begin
                u_rem_in = r_rem;
                u_quo_in = r_quo;
                u_den    = r_mag;
                u_bit    = r_dvd[DATA_W-1];
            end
            OP_DIV_A: begin
                u_rem_in = r_rem;
                u_quo_in = r_quo;
                u_den    = r_anc;
                u_bit    = r_dvd[DATA_W-1];
            end
            OP_DIV_M: begin
                u_rem_in = r_rem;
                u_quo_in = r_quo;
                u_den    = r_mag;
                u_bit    = r_dvd[DATA_W-1];
            end
            OP_SRCH_1: begin
                u_rem_in = r_r1;
                u_quo_in = r_q1;
                u_den    = r_anc;
            end
            OP_SRCH_2: begin
                u_rem_in = r_r2;
                u_quo_in = r_q2;
                u_den    = r_mag;
            end
            default: begin
                u_bit = 1'b0;
            end
        endcase
    end

    function automatic logic [SHIFT_W-1:0] n_steps_shift(input logic [STEPS_W-1:0] steps);
        logic [STEPS_W-1:0] dec;
        dec = steps - STEPS_W'(1);
        return dec[SHIFT_W-1:0];
    endfunction

    always_comb begin
        n_d     = r_d;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_anc   = r_anc;
        n_q1    = r_q1;
        n_r1    = r_r1;
        n_q2    = r_q2;
        n_r2    = r_r2;
        n_steps = r_steps;
        n_kind  = r_kind;
        n_mult  = r_mult;
        n_shift = r_shift;
        n_fix   = r_fix;
        n_dneg  = r_dneg;

        if (ctrl.in_ready && i_in_valid) begin
            n_d = i_divisor[DATA_W-1:0];
        end

        // Classification settles the trivial results and primes the first
        // division with t.
        if (ctrl.classify) begin
            n_neg   = d_neg;
            n_mag   = d_mag;
            n_mult  = '0;
            n_fix   = 1'b0;
            n_dneg  = d_neg;
            n_shift = '0;
            n_dvd   = TOP_BIT | DATA_W'(d_neg);
            n_rem   = '0;
            n_quo   = '0;
            if (d_zero) begin
                n_kind = KIND_ZERO;
            end else if (d_one) begin
                n_kind = KIND_UNIT;
            end else if (d_pow2) begin
                n_kind  = KIND_POW2;
                n_shift = SHIFT_W'(d_log2);
            end else begin
                n_kind = KIND_MAGIC;
            end
        end

        if ((ctrl.op == OP_DIV_T) || (ctrl.op == OP_DIV_A) || (ctrl.op == OP_DIV_M)) begin
            n_rem = u_rem;
            n_quo = u_quo;
            n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
            if (ctrl.last && (ctrl.op == OP_DIV_A)) begin
                n_q1  = u_quo;
                n_r1  = u_rem;
                n_dvd = TOP_BIT;
                n_rem = '0;
                n_quo = '0;
            end
            if (ctrl.last && (ctrl.op == OP_DIV_M)) begin
                n_q2    = u_quo;
                n_r2    = u_rem;
                n_steps = '0;
            end
        end

        // anc = t - 1 - (t mod |d|), never zero, then divide 2^(W-1) by it.
        if (ctrl.anc_load) begin
            n_anc = (anc_raw == '0) ? DATA_W'(1) : anc_raw;
            n_dvd = TOP_BIT;
            n_rem = '0;
            n_quo = '0;
        end

        if (ctrl.op == OP_SRCH_1) begin
            n_q1 = u_quo;
            n_r1 = u_rem;
        end

        if (ctrl.op == OP_SRCH_2) begin
            n_q2    = u_quo;
            n_r2    = u_rem;
            n_steps = r_steps + STEPS_W'(1);
        end

        // The post-shift is the exponent minus the word width, which is one
        // less than the number of search iterations.
        if (ctrl.finish) begin
            n_mult  = mult_fin;
            n_fix   = (!r_neg && mult_neg) || (r_neg && !mult_neg && (mult_fin != '0));
            n_shift = n_steps_shift(r_steps);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_anc   <= n_anc;
        r_q1    <= n_q1;
        r_r1    <= n_r1;
        r_q2    <= n_q2;
        r_r2    <= n_r2;
        r_steps <= n_steps;
        r_kind  <= n_kind;
        r_mult  <= n_mult;
        r_shift <= n_shift;
        r_fix   <= n_fix;
        r_dneg  <= n_dneg;
    end

    assign o_in_ready         = ctrl.in_ready;
    assign o_out_valid        = ctrl.out_valid;
    assign o_kind             = r_kind;
    assign o_magic_multiplier = MULT_W'(signed'(r_mult));
    assign o_shift_amount     = r_shift;
    assign o_needs_fix        = r_fix;
    assign o_divisor_negative = r_dneg;

    // The block never offers a result while it is open for a new request.
    `SMN_ASSERT_NOW(a_ready_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready,
        "result offered while input is ready")

    // An accepted request closes the input and no result appears at once.
    `SMN_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, o_in_ready && i_in_valid,
        !o_in_ready && !o_out_valid, "request accepted but block not busy")

    // Once the result is taken, the block opens for the next request.
    `SMN_ASSERT_NEXT(a_return_idle, i_clk, i_rst_n, o_out_valid && i_out_ready,
        o_in_ready && !o_out_valid, "block did not return to idle")

    // Only a general divisor carries a multiplier or a fix flag.
    `SMN_ASSERT_NOW(a_magic_only, i_clk, i_rst_n,
        o_out_valid && (o_kind != KIND_MAGIC),
        (o_magic_multiplier == '0) && !o_needs_fix,
        "multiplier or fix on a non-general divisor")

    // A zero divisor reports nothing but its kind.
    `SMN_ASSERT_NOW(a_zero_clean, i_clk, i_rst_n,
        o_out_valid && (o_kind == KIND_ZERO),
        (o_shift_amount == '0) && !o_divisor_negative,
        "zero divisor with nonzero fields")

endmodule

// ===== rtl/smn_step_unit.sv =====
// ---------------------------------------------------------------------------
// Shift-subtract step unit
// One restoring division step, shared by the three divisions and the search.
// ---------------------------------------------------------------------------
module smn_step_unit
    import smn_pkg::*;
(
    input  logic [DATA_W-1:0] i_rem,
    input  logic [DATA_W-1:0] i_quo,
    input  logic [DATA_W-1:0] i_den,
    input  logic              i_bit,
    output logic [DATA_W-1:0] o_rem,
    output logic [DATA_W-1:0] o_quo
);

    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;
    logic            ge;

    always_comb begin
        shifted = {i_rem, i_bit};
        diff    = shifted - {1'b0, i_den};
        ge      = shifted >= {1'b0, i_den};
        o_rem   = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        o_quo   = {i_quo[DATA_W-2:0], ge};
    end

endmodule

// ===== rtl/smn_ctrl.sv =====
// ---------------------------------------------------------------------------
// Planner sequencer
// Steps through classification, three divisions and the magic search.
// ---------------------------------------------------------------------------
module smn_ctrl
    import smn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             in_div;

    assign in_div = (r_state == ST_DIV_T) || (r_state == ST_DIV_A) || (r_state == ST_DIV_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The bit counter runs only inside a division and wraps after its last bit.
    always_comb begin
        n_cnt = '0;
        if (in_div && (r_cnt != CNT_LAST)) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_status.in_valid) n_state = ST_CLASS;
            ST_CLASS: n_state = i_status.trivial ? ST_OUT : ST_DIV_T;
            ST_DIV_T: if (r_cnt == CNT_LAST) n_state = ST_ANC;
            ST_ANC:   n_state = ST_DIV_A;
            ST_DIV_A: if (r_cnt == CNT_LAST) n_state = ST_DIV_M;
            ST_DIV_M: if (r_cnt == CNT_LAST) n_state = ST_SRCH1;
            ST_SRCH1: n_state = ST_SRCH2;
            ST_SRCH2: n_state = ST_TEST;
            ST_TEST:  n_state = i_status.search_more ? ST_SRCH1 : ST_FIN;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT:   if (i_status.out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl           = '0;
        o_ctrl.op        = OP_NONE;
        o_ctrl.last      = (r_cnt == CNT_LAST);
        case (r_state)
            ST_IDLE:  o_ctrl.in_ready  = 1'b1;
            ST_CLASS: o_ctrl.classify  = 1'b1;
            ST_DIV_T: o_ctrl.op        = OP_DIV_T;
            ST_ANC:   o_ctrl.anc_load  = 1'b1;
            ST_DIV_A: o_ctrl.op        = OP_DIV_A;
            ST_DIV_M: o_ctrl.op        = OP_DIV_M;
            ST_SRCH1: o_ctrl.op        = OP_SRCH_1;
            ST_SRCH2: o_ctrl.op        = OP_SRCH_2;
            ST_FIN:   o_ctrl.finish    = 1'b1;
            ST_OUT:   o_ctrl.out_valid = 1'b1;
            default:  o_ctrl.op        = OP_NONE;
        endcase
    end

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// Signed division planner testbench
// Sends signed divisors through the planner, holds the expected plan of each
// accepted request in a queue, and compares every accepted result with the
// oldest entry, field by field, under changing sender and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;
    import smn_pkg::*;

    // A full run is roughly 1550 requests, and the timeout leaves a wide
    // margin over the slowest correct run.
    localparam int CLK_PERIOD    = 20;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int RANDOM_ITEMS  = 1528;
    localparam int DRAIN_CYCLES  = 5000;
    localparam int SETTLE_CYCLES = 300;

    // One division plan, laid out like the result ports.
    typedef struct packed {
        t_kind                     kind;
        logic signed [MULT_W-1:0]  multiplier;
        logic [SHIFT_W-1:0]        shift;
        logic                      fix;
        logic                      negative;
    } t_plan;

    // A plan waiting for its result, kept with its divisor for messages.
    typedef struct {
        logic [DIVISOR_W-1:0] divisor;
        t_plan                plan;
    } t_pending;

    // One row of the directed table. When typed is set the plan is written
    // out by hand; otherwise the planner model supplies it.
    typedef struct {
        logic [DIVISOR_W-1:0] divisor;
        bit                   typed;
        t_plan                plan;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic signed [DIVISOR_W-1:0] i_divisor = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [KIND_W-1:0]           o_kind;
    logic signed [MULT_W-1:0]    o_magic_multiplier;
    logic [SHIFT_W-1:0]          o_shift_amount;
    logic                        o_needs_fix;
    logic                        o_divisor_negative;

    t_pending pending_plans[$];
    t_row     directed_rows[$];
    int       mismatch_count = 0;

    // Stall rates in percent of cycles, changed by the stimulus per phase.
    int send_idle_pct = 30;
    int recv_idle_pct = 49;

    signed_division_magic_number dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_divisor          (i_divisor),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_magic_multiplier (o_magic_multiplier),
        .o_shift_amount     (o_shift_amount),
        .o_needs_fix        (o_needs_fix),
        .o_divisor_negative (o_divisor_negative)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Computes the division plan for one divisor. The search keeps two
    // quotient/remainder pairs, one for 2^p / |nc| and one for 2^p / |d|,
    // and raises the exponent p until the multiplier is exact enough.
    // All arithmetic wraps at DATA_W bits, as the datapath does.
    function automatic t_plan plan_division(input logic [DIVISOR_W-1:0] divisor);
        logic [DATA_W-1:0] d, mag, t, anc, q1, r1, q2, r2, delta, mult;
        logic              neg, more;
        int                p, steps;
        t_plan             plan;

        plan      = '0;
        plan.kind = KIND_MAGIC;
        d         = divisor[DATA_W-1:0];
        neg       = d[DATA_W-1];
        mag       = neg ? -d : d;

        if (d == '0) begin
            plan.kind = KIND_ZERO;
        end else if (mag == DATA_W'(1)) begin
            plan.kind = KIND_UNIT;
        end else if ((mag & (mag - DATA_W'(1))) == '0) begin
            // The most negative divisor lands here too, with the top shift.
            plan.kind = KIND_POW2;
            for (int b = 0; b < DATA_W; b++) begin
                if (mag[b]) plan.shift = SHIFT_W'(b);
            end
        end else begin
            t   = TOP_BIT + DATA_W'(neg);
            anc = t - DATA_W'(1) - (t % mag);
            if (anc == '0) anc = DATA_W'(1);
            q1 = TOP_BIT / anc;
            r1 = TOP_BIT - q1 * anc;
            q2 = TOP_BIT / mag;
            r2 = TOP_BIT - q2 * mag;
            p     = DATA_W - 1;
            steps = 0;
            more  = 1'b1;
            while (more) begin
                p++;
                steps++;
                q1 = q1 << 1;
                r1 = r1 << 1;
                if (r1 >= anc) begin
                    q1 = q1 + DATA_W'(1);
                    r1 = r1 - anc;
                end
                q2 = q2 << 1;
                r2 = r2 << 1;
                if (r2 >= mag) begin
                    q2 = q2 + DATA_W'(1);
                    r2 = r2 - mag;
                end
                delta = mag - r2;
                // The step count is a safeguard; the search normally ends
                // well before it.
                more = ((q1 < delta) || (q1 == delta && r1 == '0)) && (steps < 2 * DATA_W);
            end
            mult = q2 + DATA_W'(1);
            if (neg) mult = -mult;
            plan.multiplier = MULT_W'($signed(mult));
            plan.shift      = SHIFT_W'(p - DATA_W);
            plan.fix        = (!neg && mult[DATA_W-1]) ||
                              (neg && !mult[DATA_W-1] && mult != '0);
        end
        plan.negative = neg && (d != '0);
        return plan;
    endfunction

    // Adds one directed row. Hand-typed rows never have a general kind, so
    // their multiplier and fix flag are zero.
    task automatic add_row(input logic [DIVISOR_W-1:0] divisor, input bit typed,
                           input t_kind kind, input int shift, input bit negative);
        t_row row;
        row.divisor         = divisor;
        row.typed           = typed;
        row.plan            = '0;
        row.plan.kind       = kind;
        row.plan.shift      = SHIFT_W'(shift);
        row.plan.negative   = negative;
        directed_rows.push_back(row);
    endtask

    // Sends one request. Random idle cycles go in front of it; without any,
    // valid stays high from the previous request and only the divisor moves.
    // The expected plan is queued at the edge that accepts the request.
    task automatic send_divisor(input logic [DIVISOR_W-1:0] divisor, input bit typed,
                                input t_plan typed_plan);
        t_pending entry;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_divisor  <= divisor;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        entry.divisor = divisor;
        entry.plan    = typed ? typed_plan : plan_division(divisor);
        pending_plans.push_back(entry);
    endtask

    // Holds the sender off until every queued plan has been answered.
    // Valid is only lowered when there is something to wait for, so it is
    // never lowered and raised in the same step.
    task automatic wait_for_drain();
        if (pending_plans.size() != 0) begin
            i_in_valid <= 1'b0;
            while (pending_plans.size() != 0) @(posedge i_clk);
        end
    endtask

    // Result side: check whatever the edge accepts, then choose the ready
    // level for the next cycle. Outputs are sampled before the block's own
    // updates of the same edge take effect.
    always @(posedge i_clk) begin : result_check
        t_pending want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_plans.size() == 0) begin
                flag_mismatch($sformatf("result with no request pending, kind %0d", o_kind));
            end else begin
                want = pending_plans.pop_front();
                if (o_kind !== want.plan.kind)
                    flag_mismatch($sformatf("divisor %h: kind %0d, expected %0d",
                                            want.divisor, o_kind, want.plan.kind));
                if (o_magic_multiplier !== want.plan.multiplier)
                    flag_mismatch($sformatf("divisor %h: multiplier %h, expected %h",
                                            want.divisor, o_magic_multiplier,
                                            want.plan.multiplier));
                if (o_shift_amount !== want.plan.shift)
                    flag_mismatch($sformatf("divisor %h: shift %0d, expected %0d",
                                            want.divisor, o_shift_amount, want.plan.shift));
                if (o_needs_fix !== want.plan.fix)
                    flag_mismatch($sformatf("divisor %h: needs_fix %b, expected %b",
                                            want.divisor, o_needs_fix, want.plan.fix));
                if (o_divisor_negative !== want.plan.negative)
                    flag_mismatch($sformatf("divisor %h: divisor_negative %b, expected %b",
                                            want.divisor, o_divisor_negative,
                                            want.plan.negative));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stimulus: reset, the directed table, then three random phases with
    // different stall patterns, then the drain and the final verdict.
    initial begin : stimulus
        logic [DIVISOR_W-1:0] divisor;
        int                   pick;
        int                   k;
        t_plan                no_plan;

        no_plan = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Trivial divisors and extremes, with their plans typed in.
        add_row(32'h0000_0000, 1'b1, KIND_ZERO, 0,  1'b0);
        add_row(32'h0000_0001, 1'b1, KIND_UNIT, 0,  1'b0);
        add_row(32'hFFFF_FFFF, 1'b1, KIND_UNIT, 0,  1'b1);
        add_row(32'h0000_0002, 1'b1, KIND_POW2, 1,  1'b0);
        add_row(32'hFFFF_FFFE, 1'b1, KIND_POW2, 1,  1'b1);
        add_row(32'h8000_0000, 1'b1, KIND_POW2, 31, 1'b1);
        add_row(32'h4000_0000, 1'b1, KIND_POW2, 30, 1'b0);
        add_row(32'hC000_0000, 1'b1, KIND_POW2, 30, 1'b1);
        // General divisors: small ones of both signs, ones whose multiplier
        // changes sign, and the largest magnitudes next to the extremes.
        add_row(32'd3,         1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(-32'sd3,       1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'd5,         1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(-32'sd5,       1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'd7,         1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(-32'sd7,       1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'd6,         1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'd641,       1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(-32'sd641,     1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'h7FFF_FFFF, 1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'h8000_0001, 1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'h7FFF_FFFE, 1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'h4000_0001, 1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'hBFFF_FFFF, 1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'h5555_5555, 1'b0, KIND_MAGIC, 0, 1'b0);
        add_row(32'hAAAA_AAAA, 1'b0, KIND_MAGIC, 0, 1'b0);

        foreach (directed_rows[i]) begin
            send_divisor(directed_rows[i].divisor, directed_rows[i].typed,
                         directed_rows[i].plan);
        end

        for (int phase = 0; phase < 3; phase++) begin
            // The sender waits for a full drain at each phase boundary.
            wait_for_drain();
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                pick = $urandom_range(99);
                k    = $urandom_range(1, DIVISOR_W - 1);
                if (pick < 40) begin
                    divisor = $urandom;
                end else if (pick < 70) begin
                    divisor = DIVISOR_W'($urandom_range(3, 2000));
                end else if (pick < 80) begin
                    divisor = DIVISOR_W'(1) << k;
                end else if (pick < 88) begin
                    divisor = $urandom_range(1) ? 32'h7FFF_FFFF - DIVISOR_W'($urandom_range(15))
                                                : 32'h8000_0000 + DIVISOR_W'($urandom_range(15));
                end else if (pick < 94) begin
                    divisor = $urandom_range(1) ? (DIVISOR_W'(1) << k) + DIVISOR_W'(1)
                                                : (DIVISOR_W'(1) << k) - DIVISOR_W'(1);
                end else begin
                    divisor = DIVISOR_W'($urandom_range(1));
                end
                // Random sign for the constructed magnitudes.
                if (pick >= 40 && pick < 94 && $urandom_range(1)) divisor = -divisor;
                send_divisor(divisor, 1'b0, no_plan);
            end
        end
        i_in_valid <= 1'b0;

        // Wait for the last results, with a bound, then let the block settle.
        for (int c = 0; c < DRAIN_CYCLES && pending_plans.size() != 0; c++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_plans.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", pending_plans.size()));
        end

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
